// File: design/cfpd_pkg.sv
// shared constants, types and crc helper for the can packet deframer
`timescale 1ns / 1ps

package cfpd_pkg;

  localparam int unsigned BufferBytesDef = 256;
  localparam int unsigned MaxResults     = 42;
  localparam int unsigned QueueAw        = $clog2(MaxResults);
  localparam int unsigned HdrLen         = 4;
  localparam int unsigned CrcLen         = 2;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;

  localparam logic [7:0]  Hdr1Reset  = 8'hAA;
  localparam logic [7:0]  Hdr2Reset  = 8'h55;
  localparam logic [10:0] CanIdReset = 11'd0;

  localparam int unsigned InDataW  = 104;
  localparam int unsigned InUserW  = 6;
  localparam int unsigned OutDataW = 152;
  localparam int unsigned CfgDataW = 11;

  typedef enum logic [1:0] {
    CFG_HDR_FIRST  = 2'd0,
    CFG_HDR_SECOND = 2'd1,
    CFG_CAN_ID     = 2'd2
  } cfg_idx_e;

  // one msb-first crc-16 byte update
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ CrcPoly;
      else       c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

// File: design/crc_framed_packet_deframer_unit.sv
// can frame to header/length/crc packet deframer, top level
`timescale 1ns / 1ps
// Usage
// s_axis takes one classic can frame per item: tuser holds the frame flags and
// tdata the identifier, up to eight payload bytes and their count. Frames that
// match the configured standard id are appended to a circular byte memory,
// which is then scanned for header pairs, length and a crc-16 trailer.
// m_axis gives, per input item, either one status item or one item per 8-byte
// chunk of every good packet found; tlast marks the final item of the frame.
// Each frame takes two passes over the byte memory (one byte read a cycle):
// a scan pass that records good packets in a small queue, then an emit pass
// that reads the chunk bytes back, so the counters seen on every item are the
// end-of-frame values. Steps per frame: accept, write the payload bytes,
// search for a header pair, read length and id, check the crc byte by byte,
// compare the trailer; a crc miss drops one byte and searches again. Emit:
// load each queued packet, fetch its payload bytes, then send each item.
// s_axis_tready is high only while idle.
// A stalled m_axis holds the emit pass at its output register; the last item
// may wait there while the next frame is taken. Reset empties the store,
// clears both counters and loads the header and id registers with defaults;
// the byte memory itself is not cleared.
module crc_framed_packet_deframer_unit #(
  parameter int unsigned BUFFER_BYTES = cfpd_pkg::BufferBytesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [cfpd_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // can_id[28:0], payload_bytes[92:29], payload_length[96:93], zero fill
  input  logic [cfpd_pkg::InDataW-1:0]  s_axis_tdata,
  // frame_valid, is_receive, is_standard_id, is_classic, is_error_frame, is_remote
  input  logic [cfpd_pkg::InUserW-1:0]  s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // has_packet, msg_id[8], packet_length[8], chunk_index[5], chunk_data[64],
  // last_chunk, crc_error_total[32], discarded_total[32], zero fill
  output logic [cfpd_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                          m_axis_tlast
);

  localparam int unsigned PW = $clog2(BUFFER_BYTES);
  localparam int unsigned FW = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned QW = cfpd_pkg::QueueAw;
  localparam int unsigned QEW = PW + 16;

  typedef enum logic [15:0] {
    ST_IDLE   = 16'h0001,
    ST_WR     = 16'h0002,
    ST_CHECK  = 16'h0004,
    ST_SRCH_A = 16'h0008,
    ST_SRCH_B = 16'h0010,
    ST_LEN    = 16'h0020,
    ST_ID     = 16'h0040,
    ST_CRC    = 16'h0080,
    ST_RXLO   = 16'h0100,
    ST_RXHI   = 16'h0200,
    ST_QRD    = 16'h0400,
    ST_QLD    = 16'h0800,
    ST_FETCH  = 16'h1000,
    ST_GET    = 16'h2000,
    ST_OUT    = 16'h4000,
    ST_STAT   = 16'h8000
  } state_e;

  function automatic logic [PW-1:0] wrap_f(input logic [FW:0] s);
    logic [FW:0] r;
    r = (s >= (FW+1)'(BUFFER_BYTES)) ? s - (FW+1)'(BUFFER_BYTES) : s;
    return r[PW-1:0];
  endfunction

  state_e state_q, state_d;
  logic [PW-1:0] head_q, head_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [31:0]   crcerr_q, crcerr_d, disc_q, disc_d;
  logic [7:0]    hdr1_q, hdr2_q;
  logic [10:0]   cid_q;
  logic [63:0]   pl_q, pl_d;
  logic [3:0]    wlen_q, wlen_d, wj_q, wj_d;
  logic [FW-1:0] roff_q, roff_d;
  logic [7:0]    prev_q, prev_d, len_q, len_d, id_q, id_d, rxlo_q, rxlo_d;
  logic [15:0]   crc_q, crc_d;
  logic [QW-1:0] cnt_q, cnt_d, qcnt_q, qcnt_d, qi_q, qi_d;
  logic [PW-1:0] eb_q, eb_d;
  logic [7:0]    el_q, el_d, eid_q, eid_d, bi_q, bi_d;
  logic [4:0]    k_q, k_d;
  logic [63:0]   chunk_q, chunk_d;
  logic          mv_q, mv_d, ml_q, ml_d;
  logic [cfpd_pkg::OutDataW-1:0] md_q, md_d;

  // memories
  logic [7:0]     mem [BUFFER_BYTES];
  logic [7:0]     rd_q;
  logic           mem_we;
  logic [PW-1:0]  mem_wa, mem_ra;
  logic [FW-1:0]  off_d;
  logic [QEW-1:0] qmem [cfpd_pkg::MaxResults];
  logic [QEW-1:0] qrd_q, q_wd;
  logic           q_we;

  logic          drop_en;
  logic [FW-1:0] drop_n;
  logic          in_acc, frame_ok, out_free, lastc;
  logic [3:0]    in_len;
  logic [FW:0]   fill_sum;
  logic [8:0]    tot, crc_end;
  logic [5:0]    chunks;
  logic [6:0]    cnt_sum;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign frame_ok = s_axis_tuser[0] && s_axis_tuser[1] && s_axis_tuser[2] &&
                    s_axis_tuser[3] && !s_axis_tuser[4] && !s_axis_tuser[5] &&
                    (s_axis_tdata[28:0] == {18'd0, cid_q});
  assign in_len   = (s_axis_tdata[96:93] > 4'd8) ? 4'd8 : s_axis_tdata[96:93];
  assign fill_sum = {1'b0, fill_q} + (FW+1)'(in_len);
  assign tot      = 9'd6 + {1'b0, len_q};
  assign crc_end  = 9'd4 + {1'b0, len_q};
  assign chunks   = (len_q == 8'd0) ? 6'd1 : 6'(({1'b0, len_q} + 9'd7) >> 3);
  assign cnt_sum  = {1'b0, cnt_q} + {1'b0, chunks};
  assign out_free = !mv_q || m_axis_tready;
  assign lastc    = (bi_q >= el_q);

  assign mem_wa = wrap_f({1'b0, FW'(head_q)} + {1'b0, fill_q});
  assign mem_ra = wrap_f({1'b0, FW'((state_q == ST_FETCH) ? eb_q : head_q)} + {1'b0, off_d});

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= pl_q[7:0];
    rd_q <= mem[mem_ra];
    if (q_we) qmem[qcnt_q] <= q_wd;
    qrd_q <= qmem[qi_q];
  end

  always_comb begin
    state_d = state_q;  head_d = head_q;  fill_d = fill_q;
    crcerr_d = crcerr_q; disc_d = disc_q; pl_d = pl_q; wlen_d = wlen_q; wj_d = wj_q;
    roff_d = roff_q; prev_d = prev_q; len_d = len_q; id_d = id_q; rxlo_d = rxlo_q;
    crc_d = crc_q; cnt_d = cnt_q; qcnt_d = qcnt_q; qi_d = qi_q;
    eb_d = eb_q; el_d = el_q; eid_d = eid_q; bi_d = bi_q; k_d = k_q; chunk_d = chunk_q;
    mv_d = mv_q && !m_axis_tready; ml_d = ml_q; md_d = md_q;
    off_d = '0; mem_we = 1'b0; q_we = 1'b0;
    q_wd = {wrap_f({1'b0, FW'(head_q)} + (FW+1)'(cfpd_pkg::HdrLen)), len_q, id_q};
    drop_en = 1'b0; drop_n = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cnt_d = '0; qcnt_d = '0; qi_d = '0;
          if (!frame_ok) begin
            state_d = ST_STAT;
          end else if (fill_sum > (FW+1)'(BUFFER_BYTES)) begin
            disc_d = cfpd_pkg::sat_add(disc_q, 32'(fill_sum));
            fill_d = '0;
            state_d = ST_STAT;
          end else if (in_len == 4'd0) begin
            state_d = ST_CHECK;
          end else begin
            pl_d = s_axis_tdata[92:29]; wlen_d = in_len; wj_d = '0;
            state_d = ST_WR;
          end
        end
      end
      ST_WR: begin
        mem_we = 1'b1;
        pl_d = {8'd0, pl_q[63:8]};
        fill_d = fill_q + FW'(1);
        wj_d = wj_q + 4'd1;
        if (wj_q + 4'd1 == wlen_q) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (fill_q < FW'(cfpd_pkg::HdrLen)) begin
          state_d = (qcnt_q != '0) ? ST_QRD : ST_STAT;
        end else begin
          off_d = '0; roff_d = '0; state_d = ST_SRCH_A;
        end
      end
      ST_SRCH_A: begin
        prev_d = rd_q; off_d = FW'(1); roff_d = FW'(1); state_d = ST_SRCH_B;
      end
      ST_SRCH_B: begin
        if (prev_q == hdr1_q && rd_q == hdr2_q) begin
          if (roff_q != FW'(1)) begin
            // header found further in, drop what precedes it
            drop_en = 1'b1; drop_n = roff_q - FW'(1);
            disc_d = cfpd_pkg::sat_add(disc_q, 32'(roff_q - FW'(1)));
            state_d = ST_CHECK;
          end else begin
            off_d = FW'(3); state_d = ST_LEN;
          end
        end else if (roff_q + FW'(1) < fill_q) begin
          prev_d = rd_q; off_d = roff_q + FW'(1); roff_d = off_d; state_d = ST_SRCH_B;
        end else begin
          // no pair: keep only a trailing first header byte
          drop_en = 1'b1;
          drop_n = fill_q - FW'(rd_q == hdr1_q);
          disc_d = cfpd_pkg::sat_add(disc_q, 32'(drop_n));
          state_d = ST_CHECK;
        end
      end
      ST_LEN: begin
        len_d = rd_q; off_d = FW'(2); state_d = ST_ID;
      end
      ST_ID: begin
        id_d = rd_q;
        if (9'(fill_q) < tot) begin
          state_d = (qcnt_q != '0) ? ST_QRD : ST_STAT;
        end else begin
          crc_d = cfpd_pkg::CrcInit; off_d = '0; roff_d = '0; state_d = ST_CRC;
        end
      end
      ST_CRC: begin
        crc_d = cfpd_pkg::crc_byte(crc_q, rd_q);
        if ({1'b0, roff_q} + (FW+1)'(1) < (FW+1)'(crc_end)) begin
          off_d = roff_q + FW'(1); roff_d = off_d;
        end else begin
          off_d = FW'(crc_end); state_d = ST_RXLO;
        end
      end
      ST_RXLO: begin
        rxlo_d = rd_q; off_d = FW'(crc_end + 9'd1); state_d = ST_RXHI;
      end
      ST_RXHI: begin
        if (crc_q != {rd_q, rxlo_q}) begin
          crcerr_d = cfpd_pkg::sat_add(crcerr_q, 32'd1);
          disc_d = cfpd_pkg::sat_add(disc_q, 32'd1);
          drop_en = 1'b1; drop_n = FW'(1);
          state_d = ST_CHECK;
        end else if (cnt_sum > 7'(cfpd_pkg::MaxResults)) begin
          state_d = (qcnt_q != '0) ? ST_QRD : ST_STAT;
        end else begin
          q_we = 1'b1; qcnt_d = qcnt_q + QW'(1); cnt_d = QW'(cnt_sum);
          drop_en = 1'b1; drop_n = FW'(tot);
          state_d = ST_CHECK;
        end
      end
      ST_QRD: state_d = ST_QLD;
      ST_QLD: begin
        {eb_d, el_d, eid_d} = qrd_q;
        bi_d = '0; k_d = '0; chunk_d = '0;
        state_d = (qrd_q[15:8] == 8'd0) ? ST_OUT : ST_FETCH;
      end
      ST_FETCH: begin
        off_d = FW'(bi_q); state_d = ST_GET;
      end
      ST_GET: begin
        chunk_d[8*bi_q[2:0] +: 8] = rd_q;
        bi_d = bi_q + 8'd1;
        state_d = (bi_q + 8'd1 == el_q || bi_q[2:0] == 3'd7) ? ST_OUT : ST_FETCH;
      end
      ST_OUT: begin
        if (out_free) begin
          mv_d = 1'b1;
          ml_d = lastc && (qi_q + QW'(1) == qcnt_q);
          md_d = {1'b0, disc_q, crcerr_q, lastc, chunk_q, k_q, el_q, eid_q, 1'b1};
          k_d = k_q + 5'd1; chunk_d = '0;
          if (!lastc) state_d = ST_FETCH;
          else if (qi_q + QW'(1) == qcnt_q) state_d = ST_IDLE;
          else begin
            qi_d = qi_q + QW'(1); state_d = ST_QRD;
          end
        end
      end
      ST_STAT: begin
        if (out_free) begin
          mv_d = 1'b1; ml_d = 1'b1;
          md_d = {1'b0, disc_q, crcerr_q, 87'd0};
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (drop_en) begin
      head_d = wrap_f({1'b0, FW'(head_q)} + {1'b0, drop_n});
      fill_d = fill_q - drop_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; head_q <= '0; fill_q <= '0;
      crcerr_q <= '0; disc_q <= '0; qcnt_q <= '0; qi_q <= '0; cnt_q <= '0;
      mv_q <= 1'b0;
      hdr1_q <= cfpd_pkg::Hdr1Reset; hdr2_q <= cfpd_pkg::Hdr2Reset;
      cid_q <= cfpd_pkg::CanIdReset;
    end else begin
      state_q <= state_d; head_q <= head_d; fill_q <= fill_d;
      crcerr_q <= crcerr_d; disc_q <= disc_d; qcnt_q <= qcnt_d; qi_q <= qi_d;
      cnt_q <= cnt_d; mv_q <= mv_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          cfpd_pkg::CFG_HDR_FIRST:  hdr1_q <= cfg_data_i[7:0];
          cfpd_pkg::CFG_HDR_SECOND: hdr2_q <= cfg_data_i[7:0];
          cfpd_pkg::CFG_CAN_ID:     cid_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pl_q <= pl_d; wlen_q <= wlen_d; wj_q <= wj_d; roff_q <= roff_d; prev_q <= prev_d;
    len_q <= len_d; id_q <= id_d; rxlo_q <= rxlo_d; crc_q <= crc_d;
    eb_q <= eb_d; el_q <= el_d; eid_q <= eid_d; bi_q <= bi_d; k_q <= k_d;
    chunk_q <= chunk_d; ml_q <= ml_d; md_q <= md_d;
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = md_q;
  assign m_axis_tlast  = ml_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(BUFFER_BYTES)) else $error("store fill above capacity");
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qcnt_q <= QW'(cfpd_pkg::MaxResults)) else $error("packet queue overrun");
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready) else $error("second item taken while busy");
  a_last_chunk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast && m_axis_tdata[0]) |-> m_axis_tdata[86])
    else $error("frame ended inside a packet");

endmodule

// File: tb/sv/cfpd_checker.sv
// scoreboard for the can packet deframer: predicts result items and compares them
`timescale 1ns / 1ps

module cfpd_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_idx_i,
  input  logic [cfpd_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [cfpd_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic [cfpd_pkg::InUserW-1:0]   s_axis_tuser,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [cfpd_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                           m_axis_tlast,
  output int                             fail_cnt_o,
  output int                             pending_o
);

  typedef struct packed {
    logic        has_packet;
    logic [7:0]  msg_id;
    logic [7:0]  pkt_len;
    logic [4:0]  chunk_idx;
    logic [63:0] chunk_data;
    logic        last_chunk;
    logic [31:0] crc_err_total;
    logic [31:0] discard_total;
    logic        last;
  } chunk_item_t;

  chunk_item_t  chunk_q[$];
  logic [7:0]   fifo_bytes[$];
  logic [7:0]   sync_a, sync_b;
  logic [10:0]  stream_id;
  logic [31:0]  crc_errs, discards;
  int           fails;

  assign fail_cnt_o = fails;
  assign pending_o  = chunk_q.size();

  function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // crc-16 ccitt-false over the first n bytes held
  function automatic logic [15:0] fifo_crc(input int n);
    logic [15:0] c;
    c = 16'hFFFF;
    for (int i = 0; i < n; i++) begin
      c = c ^ {fifo_bytes[i], 8'h00};
      for (int b = 0; b < 8; b++) c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  task automatic drop_bytes(input int n);
    for (int i = 0; i < n && fifo_bytes.size() > 0; i++) void'(fifo_bytes.pop_front());
  endtask

  task automatic deframe_frame(input logic [cfpd_pkg::InUserW-1:0] fl,
                               input logic [cfpd_pkg::InDataW-1:0] d);
    chunk_item_t step_q[$];
    chunk_item_t it;
    int          nb, pos, gone, plen, total, nchunks;
    bit          found;
    logic [15:0] rx;
    nb = int'(d[96:93]);
    if (nb > 8) nb = 8;
    if (fl[3:0] == 4'hF && fl[5:4] == 2'b00 && d[28:0] == {18'd0, stream_id}) begin
      if (fifo_bytes.size() + nb > cfpd_pkg::BufferBytesDef) begin
        discards = add_sat(discards, fifo_bytes.size() + nb);
        fifo_bytes.delete();
      end else begin
        for (int j = 0; j < nb; j++) fifo_bytes.insert(fifo_bytes.size(), d[29 + 8*j +: 8]);
        while (fifo_bytes.size() >= cfpd_pkg::HdrLen) begin
          found = 0;
          pos = 0;
          for (int p = 0; p + 1 < fifo_bytes.size(); p++) begin
            if (!found && fifo_bytes[p] == sync_a && fifo_bytes[p+1] == sync_b) begin
              found = 1;
              pos = p;
            end
          end
          if (!found || pos != 0) begin
            if (found) gone = pos;
            else gone = fifo_bytes.size() - ((fifo_bytes[fifo_bytes.size()-1] == sync_a) ? 1 : 0);
            discards = add_sat(discards, gone);
            drop_bytes(gone);
            if (fifo_bytes.size() < cfpd_pkg::HdrLen) break;
          end
          plen = fifo_bytes[3];
          total = cfpd_pkg::HdrLen + plen + cfpd_pkg::CrcLen;
          if (fifo_bytes.size() < total) break;
          rx = {fifo_bytes[cfpd_pkg::HdrLen + plen + 1], fifo_bytes[cfpd_pkg::HdrLen + plen]};
          if (fifo_crc(cfpd_pkg::HdrLen + plen) != rx) begin
            crc_errs = add_sat(crc_errs, 1);
            discards = add_sat(discards, 1);
            drop_bytes(1);
            continue;
          end
          nchunks = (plen == 0) ? 1 : (plen + 7) / 8;
          if (step_q.size() + nchunks > cfpd_pkg::MaxResults) break;
          for (int k = 0; k < nchunks; k++) begin
            it = '{default: '0};
            it.has_packet = 1'b1;
            it.msg_id     = fifo_bytes[2];
            it.pkt_len    = 8'(plen);
            it.chunk_idx  = 5'(k);
            for (int j = 0; j < 8; j++)
              if (k*8 + j < plen)
                it.chunk_data[8*j +: 8] = fifo_bytes[cfpd_pkg::HdrLen + k*8 + j];
            it.last_chunk = (k + 1 == nchunks);
            step_q.insert(step_q.size(), it);
          end
          drop_bytes(total);
        end
      end
    end
    if (step_q.size() == 0) begin
      it = '{default: '0};
      step_q.insert(step_q.size(), it);
    end
    foreach (step_q[i]) begin
      step_q[i].crc_err_total = crc_errs;
      step_q[i].discard_total = discards;
      step_q[i].last          = (i == step_q.size() - 1);
      chunk_q.insert(chunk_q.size(), step_q[i]);
    end
  endtask

  task automatic compare_item();
    chunk_item_t want, got;
    got.has_packet    = m_axis_tdata[0];
    got.msg_id        = m_axis_tdata[8:1];
    got.pkt_len       = m_axis_tdata[16:9];
    got.chunk_idx     = m_axis_tdata[21:17];
    got.chunk_data    = m_axis_tdata[85:22];
    got.last_chunk    = m_axis_tdata[86];
    got.crc_err_total = m_axis_tdata[118:87];
    got.discard_total = m_axis_tdata[150:119];
    got.last          = m_axis_tlast;
    if (chunk_q.size() == 0) begin
      fails++;
      if (fails <= 10) $display("unexpected item: tdata=%h tlast=%b", m_axis_tdata, m_axis_tlast);
      return;
    end
    want = chunk_q.pop_front();
    if (got != want) begin
      fails++;
      if (fails <= 10)
        $display("item mismatch: exp pkt=%b id=%h len=%0d idx=%0d data=%h lc=%b crc=%0d dis=%0d last=%b",
                 want.has_packet, want.msg_id, want.pkt_len, want.chunk_idx, want.chunk_data,
                 want.last_chunk, want.crc_err_total, want.discard_total, want.last);
      if (fails <= 10)
        $display("              got pkt=%b id=%h len=%0d idx=%0d data=%h lc=%b crc=%0d dis=%0d last=%b",
                 got.has_packet, got.msg_id, got.pkt_len, got.chunk_idx, got.chunk_data,
                 got.last_chunk, got.crc_err_total, got.discard_total, got.last);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_a    = cfpd_pkg::Hdr1Reset;
      sync_b    = cfpd_pkg::Hdr2Reset;
      stream_id = cfpd_pkg::CanIdReset;
      crc_errs  = '0;
      discards  = '0;
      fifo_bytes.delete();
      chunk_q.delete();
      fails     = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfpd_pkg::cfg_idx_e'(cfg_idx_i))
          cfpd_pkg::CFG_HDR_FIRST:  sync_a = cfg_data_i[7:0];
          cfpd_pkg::CFG_HDR_SECOND: sync_b = cfg_data_i[7:0];
          cfpd_pkg::CFG_CAN_ID:     stream_id = cfg_data_i[10:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) deframe_frame(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) compare_item();
    end
  end

endmodule

// File: tb/sv/tb_crc_framed_packet_deframer_unit.sv
// testbench top for the can packet deframer: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_crc_framed_packet_deframer_unit;

  localparam logic [cfpd_pkg::InUserW-1:0] FlagsGood = 6'b001111;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [1:0]                     cfg_idx = cfpd_pkg::CFG_HDR_FIRST;
  logic [cfpd_pkg::CfgDataW-1:0]  cfg_data = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [cfpd_pkg::InDataW-1:0]   s_axis_tdata = '0;
  logic [cfpd_pkg::InUserW-1:0]   s_axis_tuser = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [cfpd_pkg::OutDataW-1:0]  m_axis_tdata;
  logic                           m_axis_tlast;
  int                             fail_cnt, pending;

  logic [7:0]  sync_a = cfpd_pkg::Hdr1Reset, sync_b = cfpd_pkg::Hdr2Reset;
  logic [10:0] stream_id = cfpd_pkg::CanIdReset;
  logic [7:0]  tx_bytes[$];
  int          frames_sent = 0;
  bit          no_gaps = 0;
  bit          hold_out = 0;

  always #2 clk_i = ~clk_i;

  crc_framed_packet_deframer_unit dut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  cfpd_checker chk (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(20, 70);
  endfunction

  // sink side: random stall runs, or one long hold-off on request
  initial begin
    int  run;
    bit  rdy;
    run = 0;
    rdy = 1'b1;
    forever begin
      @(posedge clk_i);
      if (hold_out) begin
        m_axis_tready <= 1'b0;
        repeat (500) @(posedge clk_i);
        hold_out = 0;
      end else begin
        if (run == 0) begin
          rdy = no_gaps || ($urandom_range(0, 2) != 0);
          run = rdy ? $urandom_range(1, 12)
                    : (($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 3));
        end
        m_axis_tready <= rdy;
        run--;
      end
    end
  end

  task automatic send_frame(input logic [cfpd_pkg::InUserW-1:0] fl, input logic [28:0] id,
                            input logic [63:0] pl, input logic [3:0] nb);
    int g;
    g = pick_gap();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= fl;
    s_axis_tdata  <= {7'd0, nb, pl, id};
    do @(posedge clk_i); while (!s_axis_tready);
    frames_sent++;
  endtask

  // wait until the block is idle and every expected item has come
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0 || !s_axis_tready) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [7:0] a, input logic [7:0] b, input logic [10:0] id);
    cfg_we <= 1'b1;
    cfg_idx <= cfpd_pkg::CFG_HDR_FIRST;
    cfg_data <= {3'd0, a};
    @(posedge clk_i);
    cfg_idx <= cfpd_pkg::CFG_HDR_SECOND;
    cfg_data <= {3'd0, b};
    @(posedge clk_i);
    cfg_idx <= cfpd_pkg::CFG_CAN_ID;
    cfg_data <= id;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sync_a = a;
    sync_b = b;
    stream_id = id;
  endtask

  // header, id, length, payload and crc (low byte first) onto the byte stream
  task automatic queue_packet(input int plen, input bit bad_crc);
    logic [7:0]  pkt[$];
    logic [15:0] c;
    pkt = {sync_a, sync_b, 8'($urandom), 8'(plen)};
    repeat (plen) pkt.insert(pkt.size(), 8'($urandom));
    c = 16'hFFFF;
    foreach (pkt[i]) begin
      c = c ^ {pkt[i], 8'h00};
      for (int b = 0; b < 8; b++) c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    end
    if (bad_crc) c[$urandom_range(0, 15)] ^= 1'b1;
    pkt.insert(pkt.size(), c[7:0]);
    pkt.insert(pkt.size(), c[15:8]);
    foreach (pkt[i]) tx_bytes.insert(tx_bytes.size(), pkt[i]);
  endtask

  task automatic queue_noise(input int n);
    repeat (n) tx_bytes.insert(tx_bytes.size(), 8'($urandom));
  endtask

  // cut the stream into accepted frames of random size, with stray frames between
  task automatic flush_stream();
    logic [63:0] pl;
    int          n;
    logic [3:0]  nb;
    while (tx_bytes.size() > 0) begin
      if ($urandom_range(0, 15) == 0)
        send_frame(6'($urandom), 29'($urandom), {$urandom, $urandom}, 4'($urandom));
      n = $urandom_range(0, 8);
      if (n > tx_bytes.size()) n = tx_bytes.size();
      pl = {$urandom, $urandom};
      for (int j = 0; j < n; j++) pl[8*j +: 8] = tx_bytes.pop_front();
      nb = 4'(n);
      if (n == 8 && $urandom_range(0, 3) == 0) nb = 4'($urandom_range(9, 15));
      send_frame(FlagsGood, {18'd0, stream_id}, pl, nb);
    end
  endtask

  task automatic random_phase(input int stop_at);
    int r;
    int hogs;
    hogs = 0;
    while (frames_sent < stop_at) begin
      no_gaps = ($urandom_range(0, 5) == 0);
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_frame(6'($urandom), 29'($urandom), {$urandom, $urandom}, 4'($urandom));
      end else if (r < 10 && hogs == 0) begin
        // length byte too large to fit: store fills and overflows
        hogs++;
        tx_bytes = {sync_a, sync_b, 8'h00, 8'hFF};
        queue_noise(260);
        flush_stream();
      end else begin
        if ($urandom_range(0, 3) == 0) queue_noise($urandom_range(1, 5));
        if ($urandom_range(0, 4) == 0) tx_bytes.insert(tx_bytes.size(), sync_a);
        if ($urandom_range(0, 24) == 0) queue_packet($urandom_range(100, 250), 0);
        else queue_packet($urandom_range(0, 24), $urandom_range(0, 5) == 0);
        flush_stream();
      end
    end
    no_gaps = 0;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // rejected frames: each flag wrong, id wrong only above bit 10, id all ones; then an empty good frame
    send_frame(6'b001110, 29'd0, '1, 4'd8);
    send_frame(6'b001101, 29'd0, '1, 4'd8);
    send_frame(6'b001011, 29'd0, '1, 4'd8);
    send_frame(6'b000111, 29'd0, '1, 4'd8);
    send_frame(6'b011111, 29'd0, '1, 4'd8);
    send_frame(6'b101111, 29'd0, '1, 4'd8);
    send_frame(FlagsGood, 29'h1000_0000, '1, 4'd8);
    send_frame(FlagsGood, '1, 64'd0, 4'd15);
    send_frame(FlagsGood, 29'd0, '1, 4'd0);
    // zero-length packet, bad crc packet, trailing first sync byte, then a nine-byte packet
    queue_packet(0, 0);
    flush_stream();
    queue_packet(2, 1);
    queue_noise(3);
    tx_bytes.insert(tx_bytes.size(), sync_a);
    flush_stream();
    queue_packet(9, 0);
    flush_stream();
    drain();

    set_regs(8'hFF, 8'h00, 11'h7FF);
    random_phase(110);
    drain();

    set_regs(8'h00, 8'hFF, 11'h123);
    hold_out = 1;
    random_phase(210);
    drain();

    set_regs(8'h7E, 8'h7E, 11'($urandom));
    random_phase(320);
    drain();
    repeat (600) @(posedge clk_i);

    if (fail_cnt == 0 && pending == 0) begin
      $display("tb_crc_framed_packet_deframer_unit: clean");
    end else begin
      $display("tb_crc_framed_packet_deframer_unit: errors");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("tb_crc_framed_packet_deframer_unit: errors");
    $finish;
  end

endmodule
